>>> hw/rtl/msvg_pkg.sv
`default_nettype none
package msvg_pkg;

  // CORDIC shared by the rotation and vectoring units
  localparam int CORDIC_STEPS    = 24;
  localparam int CORDIC_GAIN_Q30 = 652032874;
  localparam int ROT_LAT         = CORDIC_STEPS + 2;
  localparam int VEC_LAT         = CORDIC_STEPS + 2;

  // dividers: 9-bit index shifted up by 31, or 8-bit segment shifted up by 32
  localparam int DIV_W    = 40;
  localparam int LVL_W    = 8;
  // isqrt: 16 iterations plus the cap register
  localparam int SQRT_LAT = 17;

  // radians to binary turns, 2^32 / 2pi
  localparam logic signed [31:0] RAD_TO_TURNS = 32'sd683565276;

  // configuration register indexes
  localparam logic [2:0] REG_TWIST    = 3'd0;
  localparam logic [2:0] REG_CONVEX   = 3'd1;
  localparam logic [2:0] REG_ZROT     = 3'd2;
  localparam logic [2:0] REG_LAT_LVL  = 3'd3;
  localparam logic [2:0] REG_LON_LVL  = 3'd4;
  localparam logic [2:0] REG_OPEN_TOP = 3'd5;
  localparam logic [2:0] REG_EQ_AREA  = 3'd6;
  localparam logic [2:0] REG_WITH_TEX = 3'd7;

  // atan(2^-i) in binary turns
  function automatic logic [31:0] atan_turn(input int i);
    case (i)
      0:  atan_turn = 32'h20000000;
      1:  atan_turn = 32'h12E4051E;
      2:  atan_turn = 32'h09FB385B;
      3:  atan_turn = 32'h051111D4;
      4:  atan_turn = 32'h028B0D43;
      5:  atan_turn = 32'h0145D7E1;
      6:  atan_turn = 32'h00A2F61E;
      7:  atan_turn = 32'h00517C55;
      8:  atan_turn = 32'h0028BE53;
      9:  atan_turn = 32'h00145F2F;
      10: atan_turn = 32'h000A2F98;
      11: atan_turn = 32'h000517CC;
      12: atan_turn = 32'h00028BE6;
      13: atan_turn = 32'h000145F3;
      14: atan_turn = 32'h0000A2FA;
      15: atan_turn = 32'h0000517D;
      16: atan_turn = 32'h000028BE;
      17: atan_turn = 32'h0000145F;
      18: atan_turn = 32'h00000A30;
      19: atan_turn = 32'h00000518;
      20: atan_turn = 32'h0000028C;
      21: atan_turn = 32'h00000146;
      22: atan_turn = 32'h000000A3;
      23: atan_turn = 32'h00000051;
      default: atan_turn = 32'h0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/morphed_sphere_vertex_generator.sv
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    ring_sel, seg_sel
// m_       out  m_tvalid/m_tready    pos_x, pos_y, pos_z, tex_u, tex_v
// cfg_     in   cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled.
// Pipeline: 40-stage dividers (one quotient bit per stage), then two 26-stage
// CORDIC rotators in series, plus eight multiply and rounding stages.
// Reset clears the valid line and loads the register defaults; no clearing pass.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
`default_nettype none
module morphed_sphere_vertex_generator import msvg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,    // ring_sel[7:0], seg_sel[15:8]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [95:0] m_tdata,    // pos_x[19:0], pos_y[39:20], pos_z[59:40],
                                       // tex_u[75:60], tex_v[91:76], zero[95:92]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int LAT = DIV_W + 2 * ROT_LAT + 8;

  // configuration registers
  logic signed [15:0] twist_q, convex_q, zrot_q;
  logic [7:0]         lat_lvl_q, lon_lvl_q;
  logic               open_top_q, eq_area_q, with_tex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twist_q    <= '0;
      convex_q   <= '0;
      zrot_q     <= '0;
      lat_lvl_q  <= 8'd2;
      lon_lvl_q  <= 8'd3;
      open_top_q <= 1'b0;
      eq_area_q  <= 1'b0;
      with_tex_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TWIST:    twist_q    <= $signed(cfg_data_i);
        REG_CONVEX:   convex_q   <= $signed(cfg_data_i);
        REG_ZROT:     zrot_q     <= $signed(cfg_data_i);
        REG_LAT_LVL:  lat_lvl_q  <= cfg_data_i[7:0];
        REG_LON_LVL:  lon_lvl_q  <= cfg_data_i[7:0];
        REG_OPEN_TOP: open_top_q <= cfg_data_i[0];
        REG_EQ_AREA:  eq_area_q  <= cfg_data_i[0];
        REG_WITH_TEX: with_tex_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // global advance and valid line
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_tvalid};
    end
  end

  // dividends: latitude in turns or equal-area rounding, longitude in turns
  logic [LVL_W-1:0] tl, pl;
  logic [8:0]       k;
  logic [DIV_W-1:0] lat_dvd, lon_dvd, lat_quo, lon_quo;

  assign tl      = (lat_lvl_q == '0) ? LVL_W'(1) : lat_lvl_q;
  assign pl      = (lon_lvl_q == '0) ? LVL_W'(1) : lon_lvl_q;
  assign k       = 9'(s_tdata[7:0]) + 9'(open_top_q);
  assign lat_dvd = eq_area_q ? (DIV_W'({k, 16'h0000}) + DIV_W'(tl >> 1)) : {k, 31'h0};
  assign lon_dvd = {s_tdata[15:8], 32'h0};

  msvg_div #(.N(DIV_W), .DW(LVL_W)) u_div_lat (
    .clk_i, .en_i(en), .dividend_i(lat_dvd), .divisor_i(tl), .quot_o(lat_quo));
  msvg_div #(.N(DIV_W), .DW(LVL_W)) u_div_lon (
    .clk_i, .en_i(en), .dividend_i(lon_dvd), .divisor_i(pl), .quot_o(lon_quo));

  // angle-mode latitude cos/sin
  logic signed [15:0] ct_ang, st_ang;

  msvg_rot u_rot_lat (
    .clk_i, .en_i(en), .turn_i(lat_quo[31:0]), .cos_o(ct_ang), .sin_o(st_ang));

  // equal-area latitude: clamp cosine, square, root
  logic signed [25:0] ctf;
  logic signed [15:0] ct_ea_q, ct_ea_d, ct_ea_al, st_ea, st_ea_al;
  logic signed [31:0] ct_sq;
  logic [30:0]        rad_q;

  assign ctf     = 26'sd32768 - $signed({1'b0, lat_quo[24:0]});
  assign ct_ea_d = (ctf > 26'sd32767) ? 16'sh7FFF :
                   (ctf < -26'sd32768) ? 16'sh8000 : ctf[15:0];
  assign ct_sq   = ct_ea_q * ct_ea_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ct_ea_q <= ct_ea_d;
      rad_q   <= 31'(32'sh40000000 - ct_sq);
    end
  end

  msvg_sqrt u_sqrt (.clk_i, .en_i(en), .rad_i(rad_q), .root_o(st_ea));

  msvg_dly #(.W(16), .D(ROT_LAT - 1)) u_dly_ctea (
    .clk_i, .en_i(en), .d_i(ct_ea_q), .q_o(ct_ea_al));
  msvg_dly #(.W(16), .D(ROT_LAT - 2 - SQRT_LAT)) u_dly_stea (
    .clk_i, .en_i(en), .d_i(st_ea), .q_o(st_ea_al));

  // longitude aligned with the twist turn
  logic [DIV_W-1:0] lon_al;
  msvg_dly #(.W(DIV_W), .D(ROT_LAT + 3)) u_dly_lon (
    .clk_i, .en_i(en), .d_i(lon_quo), .q_o(lon_al));

  // coefficient products
  logic signed [15:0] ct_q, st_q, st2_q;
  logic signed [31:0] ptw_q, pzr_q, onep_q;
  logic signed [63:0] tprod, zprod_t;
  logic signed [47:0] rprod;
  logic        [31:0] tturn_q, zturn_q, zturn2_q, bturn_q;
  logic signed [32:0] r_q;

  assign tprod   = ptw_q * RAD_TO_TURNS;
  assign zprod_t = pzr_q * RAD_TO_TURNS;
  assign rprod   = onep_q * st2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ct_q     <= eq_area_q ? ct_ea_al : ct_ang;
      st_q     <= eq_area_q ? st_ea_al : st_ang;
      ptw_q    <= ct_q * twist_q;
      pzr_q    <= ct_q * zrot_q;
      onep_q   <= 32'sh08000000 + ct_q * convex_q;
      st2_q    <= st_q;
      tturn_q  <= tprod[58:27];
      zturn_q  <= zprod_t[58:27];
      r_q      <= rprod[47:15];
      zturn2_q <= zturn_q;
      bturn_q  <= lon_al[31:0] + tturn_q;
    end
  end

  // longitude plus twist, and z rotation
  logic signed [15:0] cb, sb, c2, s2;

  msvg_rot u_rot_b (.clk_i, .en_i(en), .turn_i(bturn_q), .cos_o(cb), .sin_o(sb));
  msvg_rot u_rot_z (.clk_i, .en_i(en), .turn_i(zturn2_q), .cos_o(c2), .sin_o(s2));

  logic signed [32:0] r_al;
  logic signed [15:0] ct_al;

  msvg_dly #(.W(33), .D(ROT_LAT + 1)) u_dly_r (
    .clk_i, .en_i(en), .d_i(r_q), .q_o(r_al));
  msvg_dly #(.W(16), .D(ROT_LAT + 3)) u_dly_ct (
    .clk_i, .en_i(en), .d_i(ct_q), .q_o(ct_al));

  // radius onto the circle, then rotation about z
  logic signed [48:0] yprod, zprod;
  logic signed [33:0] y_q, z97_q, z98_q, z99_q;
  logic signed [27:0] xq_q;
  logic signed [15:0] c2_q, s2_q;
  logic signed [43:0] pa, pc;
  logic signed [49:0] pb, pe;
  logic signed [28:0] a_q, c_q;
  logic signed [34:0] b_q, e_q;
  logic signed [35:0] r0_q, r1_q;

  assign yprod = r_al * cb;
  assign zprod = r_al * sb;
  assign pa    = xq_q * c2_q;
  assign pb    = y_q * s2_q;
  assign pc    = xq_q * s2_q;
  assign pe    = y_q * c2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q   <= yprod[48:15];
      z97_q <= zprod[48:15];
      xq_q  <= {ct_al, 12'h000};
      c2_q  <= c2;
      s2_q  <= s2;
      a_q   <= pa[43:15];
      b_q   <= pb[49:15];
      c_q   <= pc[43:15];
      e_q   <= pe[49:15];
      z98_q <= z97_q;
      r0_q  <= 36'(a_q) - 36'(b_q);
      r1_q  <= 36'(c_q) + 36'(e_q);
      z99_q <= z98_q;
    end
  end

  // texture coordinates
  logic [15:0] v_tex, v_al;
  logic [23:0] u_al;

  msvg_vec u_vec (.clk_i, .en_i(en), .ct_i(ct_q), .st_i(st_q), .v_o(v_tex));
  msvg_dly #(.W(16), .D(ROT_LAT + 6 - VEC_LAT)) u_dly_v (
    .clk_i, .en_i(en), .d_i(v_tex), .q_o(v_al));
  msvg_dly #(.W(24), .D(ROT_LAT + 4)) u_dly_u (
    .clk_i, .en_i(en), .d_i(lon_al[39:16]), .q_o(u_al));

  // round Q27 to Q7.12 and saturate
  function automatic logic [19:0] pos_round(input logic signed [35:0] v);
    logic signed [36:0] t;
    t = (37'(v) + 37'sd16384) >>> 15;
    if (t > 37'sd524287) pos_round = 20'h7FFFF;
    else if (t < -37'sd524288) pos_round = 20'h80000;
    else pos_round = t[19:0];
  endfunction

  // output register
  logic [19:0] px_q, py_q, pz_q;
  logic [15:0] tu_q, tv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= pos_round(r0_q);
      py_q <= pos_round(r1_q);
      pz_q <= pos_round(36'(z99_q));
      tu_q <= !with_tex_q ? 16'h0000 : ((u_al[23:16] != '0) ? 16'hFFFF : u_al[15:0]);
      tv_q <= with_tex_q ? v_al : 16'h0000;
    end
  end

  assign m_tdata = {4'h0, tv_q, tu_q, pz_q, py_q, px_q};

endmodule
`default_nettype wire

>>> hw/rtl/msvg_dly.sv
`default_nettype none
module msvg_dly #(
  parameter int W = 16,
  parameter int D = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] pipe_q [D];

  // alignment shift line, advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[D-1];

endmodule
`default_nettype wire

>>> hw/rtl/msvg_div.sv
`default_nettype none
module msvg_div import msvg_pkg::*; #(
  parameter int N  = DIV_W,
  parameter int DW = LVL_W
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [N-1:0]  dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic      [N-1:0]  quot_o
);

  logic [DW-1:0] rem_q  [N];
  logic [N-1:0]  work_q [N];

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [N-1:0]  work_in;
    logic [DW:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
    end

    assign trial = {rem_in, work_in[N-1]};
    assign take  = trial >= {1'b0, divisor_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? DW'(trial - {1'b0, divisor_i}) : trial[DW-1:0];
        work_q[s] <= {work_in[N-2:0], take};
      end
    end
  end

  assign quot_o = work_q[N-1];

endmodule
`default_nettype wire

>>> hw/rtl/msvg_rot.sv
`default_nettype none
module msvg_rot import msvg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic        [31:0] turn_i,
  output logic signed      [15:0] cos_o,
  output logic signed      [15:0] sin_o
);

  localparam int XW = 34;
  localparam int ZW = 33;

  logic signed [XW-1:0] x_q    [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q    [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q    [CORDIC_STEPS+1];
  logic        [1:0]    quad_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] cx, sy;
  logic signed [15:0]   cos_q, sin_q;

  function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v + XW'(16384)) >>> 15;
    if (t > XW'(32767)) sat16 = 16'sh7FFF;
    else if (t < -XW'(32768)) sat16 = 16'sh8000;
    else sat16 = t[15:0];
  endfunction

  // quadrant split, residual angle in the first quadrant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= XW'(CORDIC_GAIN_Q30);
      y_q[0]    <= '0;
      z_q[0]    <= $signed({3'b000, turn_i[29:0]});
      quad_q[0] <= turn_i[31:30];
    end
  end

  // micro-rotations
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_iter
    logic signed [ZW-1:0] ang;
    assign ang = $signed(ZW'(atan_turn(s)));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[s+1] <= quad_q[s];
        if (!z_q[s][ZW-1]) begin
          x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] - ang;
        end else begin
          x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] + ang;
        end
      end
    end
  end

  // quadrant fold back
  always_comb begin
    case (quad_q[CORDIC_STEPS])
      2'd0: begin
        cx = x_q[CORDIC_STEPS];
        sy = y_q[CORDIC_STEPS];
      end
      2'd1: begin
        cx = -y_q[CORDIC_STEPS];
        sy = x_q[CORDIC_STEPS];
      end
      2'd2: begin
        cx = -x_q[CORDIC_STEPS];
        sy = -y_q[CORDIC_STEPS];
      end
      default: begin
        cx = y_q[CORDIC_STEPS];
        sy = -x_q[CORDIC_STEPS];
      end
    endcase
  end

  // round to Q1.15
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= sat16(cx);
      sin_q <= sat16(sy);
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule
`default_nettype wire

>>> hw/rtl/msvg_vec.sv
`default_nettype none
module msvg_vec import msvg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] ct_i,
  input  wire logic signed [15:0] st_i,
  output logic             [15:0] v_o
);

  localparam int XW = 34;

  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] z_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] st_w, xs, ys, zs;
  logic        [15:0]   v_q;

  assign st_w = XW'(st_i);
  assign xs   = XW'(ct_i) <<< 15;
  assign ys   = (st_w[XW-1] ? -st_w : st_w) <<< 15;

  // left half plane turns by a quarter first
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (xs[XW-1]) begin
        x_q[0] <= ys;
        y_q[0] <= -xs;
        z_q[0] <= XW'(32'h40000000);
      end else begin
        x_q[0] <= xs;
        y_q[0] <= ys;
        z_q[0] <= '0;
      end
    end
  end

  // drive y toward zero, collect the angle
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_iter
    logic signed [XW-1:0] ang;
    assign ang = $signed(XW'(atan_turn(s)));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[s][XW-1] && (y_q[s] != '0)) begin
          x_q[s+1] <= x_q[s] + (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] - (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] + ang;
        end else begin
          x_q[s+1] <= x_q[s] - (y_q[s] >>> s);
          y_q[s+1] <= y_q[s] + (x_q[s] >>> s);
          z_q[s+1] <= z_q[s] - ang;
        end
      end
    end
  end

  // half turn maps to 65536, clamp to Q0.16
  assign zs = z_q[CORDIC_STEPS] >>> 15;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zs[XW-1]) v_q <= '0;
      else if (zs > XW'(65535)) v_q <= 16'hFFFF;
      else v_q <= zs[15:0];
    end
  end

  assign v_o = v_q;

endmodule
`default_nettype wire

>>> hw/rtl/msvg_sqrt.sv
`default_nettype none
module msvg_sqrt import msvg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic        [30:0] rad_i,
  output logic signed      [15:0] root_o
);

  localparam int STEPS = SQRT_LAT - 1;
  localparam int VW    = 32;

  logic [VW-1:0]      v_q [STEPS];
  logic [VW-1:0]      r_q [STEPS];
  logic signed [15:0] root_q;

  // digit-by-digit square root, one result bit per stage
  for (genvar s = 0; s < STEPS; s++) begin : g_iter
    localparam logic [VW-1:0] BITV = VW'(1) << (2 * (STEPS - 1 - s));
    logic [VW-1:0] v_in, r_in, sum;

    if (s == 0) begin : g_first
      assign v_in = VW'(rad_i);
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = r_q[s-1];
    end

    assign sum = r_in + BITV;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= sum) begin
          v_q[s] <= v_in - sum;
          r_q[s] <= (r_in >> 1) + BITV;
        end else begin
          v_q[s] <= v_in;
          r_q[s] <= r_in >> 1;
        end
      end
    end
  end

  // root of 2^30 caps to the Q1.15 maximum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= (r_q[STEPS-1] > VW'(32767)) ? 16'sh7FFF : $signed(r_q[STEPS-1][15:0]);
    end
  end

  assign root_o = root_q;

endmodule
`default_nettype wire

>>> hw/rtl/msvg_checker.sv
`default_nettype none
module msvg_checker import msvg_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [15:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [15:0] cfg_data_i
);

  // mirror of the texture enable seen on the config port
  logic tex_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_WITH_TEX)) begin
      tex_q <= cfg_data_i[0];
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result item changed while stalled");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output advance");

  a_tex_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !tex_q && !(s_tvalid && s_tdata == 16'h0 && 1'b0) |-> m_tdata[91:60] == '0)
    else $error("texture fields nonzero with texturing off");

endmodule

bind morphed_sphere_vertex_generator msvg_checker u_msvg_checker (.*);
`default_nettype wire
